// ===== rtl/core/indexed_log_window_store_assert.svh =====
// assertion helpers shared by the log window store modules
`ifndef INDEXED_LOG_WINDOW_STORE_ASSERT_SVH
`define INDEXED_LOG_WINDOW_STORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define ILWS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("log window store check failed");

// next-cycle implication, checked out of reset
`define ILWS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("log window store check failed");

`endif

// ===== rtl/core/ilws_pkg.sv =====
package ilws_pkg;

    // ring geometry
    localparam int DEPTH         = 1024;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int SLOT_W        = $clog2(DEPTH);
    localparam int CNT_W         = $clog2(DEPTH + 1);

    // field widths on the ports
    localparam int IDX_W   = 63;
    localparam int TERM_W  = 63;
    localparam int PAY_F_W = 32;

    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_APPEND   = 3'd1,
        OP_TRUNC_PR = 3'd2,
        OP_TRUNC_SF = 3'd3,
        OP_RESET    = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_OUTSIDE   = 3'd1,
        ST_NOT_NEXT  = 3'd2,
        ST_FULL      = 3'd3,
        ST_BAD_RESET = 3'd4
    } status_t;

    // one access to the ring memory
    typedef struct packed {
        logic                     rd_en;
        logic                     wr_en;
        logic [SLOT_W-1:0]        slot;
        logic [TERM_W-1:0]        term;
        logic [PAYLOAD_WIDTH-1:0] payload;
    } mem_req_t;

    // per-request outcome of the window logic
    typedef struct packed {
        status_t           status;
        logic              hit;
        logic [63:0]       first;
        logic [IDX_W-1:0]  last;
    } res_t;

    // ring slot plus offset, offset at most DEPTH
    function automatic logic [SLOT_W-1:0] slot_add(
        input logic [SLOT_W-1:0] head,
        input logic [CNT_W-1:0]  off
    );
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(head) + (CNT_W + 1)'(off);
        if (sum >= (CNT_W + 1)'(DEPTH)) begin
            sum = sum - (CNT_W + 1)'(DEPTH);
        end
        return SLOT_W'(sum);
    endfunction

endpackage

// ===== rtl/core/ilws_ring_mem.sv =====
module ilws_ring_mem
    import ilws_pkg::*;
(
    input  logic                     aclk,
    input  mem_req_t                 req,
    output logic [TERM_W-1:0]        rd_term,
    output logic [PAYLOAD_WIDTH-1:0] rd_payload
);

    logic [TERM_W-1:0]        term_mem [DEPTH];
    logic [PAYLOAD_WIDTH-1:0] pay_mem  [DEPTH];

    // single port: a request either writes or reads one slot
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            term_mem[req.slot] <= req.term;
            pay_mem[req.slot]  <= req.payload;
        end
        if (req.rd_en) begin
            rd_term    <= term_mem[req.slot];
            rd_payload <= pay_mem[req.slot];
        end
    end

endmodule

// ===== rtl/core/ilws_window_ctrl.sv =====
`include "indexed_log_window_store_assert.svh"

module ilws_window_ctrl
    import ilws_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               req_valid,
    input  logic [2:0]         op,
    input  logic [IDX_W-1:0]   idx,
    input  logic [TERM_W-1:0]  term,
    input  logic [PAY_F_W-1:0] payload,
    output mem_req_t           mem_req,
    output res_t               res
);

    logic [63:0]       first_reg, first_next;
    logic [IDX_W-1:0]  last_reg, last_next;
    logic [SLOT_W-1:0] head_reg, head_next;

    logic [63:0]      idx64;
    logic [63:0]      lastp1;
    logic [CNT_W-1:0] count;
    logic [CNT_W-1:0] offset;
    logic [CNT_W-1:0] drop;
    logic             in_window;
    status_t          status;
    logic             hit;

    // window arithmetic; held count never exceeds DEPTH so low bits suffice
    assign idx64     = {1'b0, idx};
    assign lastp1    = {1'b0, last_reg} + 64'd1;
    assign count     = lastp1[CNT_W-1:0] - first_reg[CNT_W-1:0];
    assign offset    = idx[CNT_W-1:0] - first_reg[CNT_W-1:0];
    assign in_window = (idx64 >= first_reg) && (idx <= last_reg);
    assign drop      = (idx64 > lastp1) ? count : offset;

    // decode one request
    always_comb begin
        first_next      = first_reg;
        last_next       = last_reg;
        head_next       = head_reg;
        status          = ST_OK;
        hit             = 1'b0;
        mem_req.rd_en   = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.slot    = slot_add(head_reg, offset);
        mem_req.term    = term;
        mem_req.payload = payload[PAYLOAD_WIDTH-1:0];
        case (op_t'(op))
            OP_READ: begin
                if (in_window) begin
                    hit           = 1'b1;
                    mem_req.rd_en = req_valid;
                end else begin
                    status = ST_OUTSIDE;
                end
            end
            OP_APPEND: begin
                mem_req.slot = slot_add(head_reg, count);
                if (idx64 != lastp1) begin
                    status = ST_NOT_NEXT;
                end else if (count >= CNT_W'(DEPTH)) begin
                    status = ST_FULL;
                end else begin
                    mem_req.wr_en = req_valid;
                    last_next     = idx;
                end
            end
            OP_TRUNC_PR: begin
                // a prefix cut below the window would widen it: ignored
                if (idx64 >= first_reg) begin
                    head_next  = slot_add(head_reg, drop);
                    first_next = idx64;
                    if (idx > last_reg) begin
                        last_next = idx - IDX_W'(1);
                    end
                end
            end
            OP_TRUNC_SF: begin
                // a suffix cut above the window would widen it: ignored
                if (idx <= last_reg) begin
                    last_next = idx;
                    if (first_reg > idx64) begin
                        first_next = idx64 + 64'd1;
                    end
                end
            end
            OP_RESET: begin
                if (idx == '0) begin
                    status = ST_BAD_RESET;
                end else begin
                    first_next = idx64;
                    last_next  = idx - IDX_W'(1);
                    head_next  = '0;
                end
            end
            default: begin
            end
        endcase
    end

    assign res.status = status;
    assign res.hit    = hit;
    assign res.first  = first_next;
    assign res.last   = last_next;

    // window registers, empty window starting at index one
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg <= 64'd1;
            last_reg  <= '0;
            head_reg  <= '0;
        end else if (req_valid) begin
            first_reg <= first_next;
            last_reg  <= last_next;
            head_reg  <= head_next;
        end
    end

    `ILWS_ASSERT_IMP(a_count_bound, 1'b1, (lastp1 - first_reg) <= 64'(DEPTH))
    `ILWS_ASSERT_IMP(a_first_nonzero, 1'b1, first_reg != 64'd0)
    `ILWS_ASSERT_IMP(a_write_is_append, mem_req.wr_en, !mem_req.rd_en && status == ST_OK && op == OP_APPEND)

endmodule

// ===== rtl/core/indexed_log_window_store.sv =====
// indexed_log_window_store: ring store of consecutive log entries
//
// Requests enter on the s_ channel: s_tuser carries the operation (read,
// append, prefix cut, suffix cut, restart) and s_tdata the index, term and
// payload. Every request gives exactly one result on the m_ channel with a
// status, the read term and payload (zero unless a read hits) and the window
// bounds after the request.
// A request passes the window logic and ring memory access into stage one,
// then the output register. Throughput is one request per cycle while the
// receiver takes results; the single memory port is used by at most one
// read or one write per request, and a read always sees earlier writes.
// When the receiver stalls, the output register and the stage behind it
// fill, and s_tready drops until the output register is taken; the memory
// read data is held while stalled since no new request reads.
// Synchronous reset (aresetn low) empties the window (first index 1, last
// index 0) and drops any result in flight; memory contents are not cleared,
// as slots outside the window are never read.
module indexed_log_window_store
    import ilws_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // index [62:0], term [125:63], payload [157:126], zero [159:158]
    input  logic [159:0] s_tdata,
    // operation [2:0]
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status [2:0], term_out [65:3], payload_out [97:66],
    // first_index_out [160:98], last_index_out [223:161]
    output logic [223:0] m_tdata
);

    mem_req_t                 mem_req;
    res_t                     res;
    logic [TERM_W-1:0]        rd_term;
    logic [PAYLOAD_WIDTH-1:0] rd_payload;

    logic         s_accept;
    logic         out_free;
    logic         s1_valid_reg, s1_valid_next;
    res_t         s1_res_reg;
    logic         m_valid_reg, m_valid_next;
    logic [223:0] m_tdata_reg, m_tdata_next;
    logic [TERM_W-1:0]  term_sel;
    logic [PAY_F_W-1:0] pay_sel;

    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_accept = s_tvalid && s_tready;

    ilws_window_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_accept),
        .op        (s_tuser),
        .idx       (s_tdata[62:0]),
        .term      (s_tdata[125:63]),
        .payload   (s_tdata[157:126]),
        .mem_req   (mem_req),
        .res       (res)
    );

    ilws_ring_mem u_mem (
        .aclk       (aclk),
        .req        (mem_req),
        .rd_term    (rd_term),
        .rd_payload (rd_payload)
    );

    // stage one: waits for the memory read data
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_accept) begin
            s1_valid_next = 1'b1;
        end else if (out_free) begin
            s1_valid_next = 1'b0;
        end
    end

    // result assembly, term and payload only for a hit
    assign term_sel = s1_res_reg.hit ? rd_term : '0;
    assign pay_sel  = s1_res_reg.hit ? PAY_F_W'(rd_payload) : '0;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_tdata_next = m_tdata_reg;
        if (out_free) begin
            m_valid_next = s1_valid_reg;
            m_tdata_next = {s1_res_reg.last, s1_res_reg.first[62:0], pay_sel, term_sel,
                            s1_res_reg.status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_res_reg <= res;
        end
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;

    `ILWS_ASSERT_IMP(a_no_accept_blocked, s1_valid_reg && !out_free, !s_accept)
    `ILWS_ASSERT_NEXT(a_stage_held, s1_valid_reg && !out_free, s1_valid_reg)
    `ILWS_ASSERT_IMP(a_miss_zero, m_tvalid && m_tdata[2:0] != ST_OK, m_tdata[97:3] == '0)

endmodule
